// ----- sv/dvpf_pkg.sv -----
// Shared types, register codes and constants of the dual velocity regulator.
package dvpf_pkg;

	localparam int SPEED_WIDTH_DEF    = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	localparam int GAIN_WIDTH      = 16;
	localparam int LIMIT_WIDTH     = 11;
	localparam int DRIVE_WIDTH     = 11;
	localparam int STEP_FRAC_BITS  = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam logic signed [DRIVE_WIDTH-1:0] PWM_MAX = 11'sd1023;
	localparam logic signed [DRIVE_WIDTH-1:0] PWM_MIN = -11'sd1023;

	localparam logic signed [LIMIT_WIDTH-1:0] INTEG_UPPER_RST = 11'sd50;
	localparam logic signed [LIMIT_WIDTH-1:0] INTEG_LOWER_RST = -11'sd50;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FF_GAIN     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCEL_GAIN  = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ISTEP_GAIN  = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_UPPER = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_LOWER = 3'd5;

	typedef struct packed {
		logic [GAIN_WIDTH-1:0]  ff_gain;
		logic [GAIN_WIDTH-1:0]  accel_gain;
		logic [GAIN_WIDTH-1:0]  prop_gain;
		logic [GAIN_WIDTH-1:0]  istep_gain;
		logic [LIMIT_WIDTH-1:0] integ_upper;
		logic [LIMIT_WIDTH-1:0] integ_lower;
	} cfg_t;

	typedef struct packed {
		logic load_s1;
		logic adv_s1;
		logic adv_s2;
	} pipe_ctl_t;

endpackage

// ----- sv/dvpf_if.sv -----
// Handshake channels: input samples, drive commands and register writes.
interface dvpf_in_if #(parameter int SPEED_WIDTH = dvpf_pkg::SPEED_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SPEED_WIDTH-1:0] target_a;
	logic signed [SPEED_WIDTH-1:0] target_b;
	logic signed [SPEED_WIDTH-1:0] speed_a;
	logic signed [SPEED_WIDTH-1:0] speed_b;
	modport source (output valid, target_a, target_b, speed_a, speed_b, input ready);
	modport sink (input valid, target_a, target_b, speed_a, speed_b, output ready);
endinterface

interface dvpf_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] drive_a;
	logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] drive_b;
	modport source (output valid, drive_a, drive_b, input ready);
	modport sink (input valid, drive_a, drive_b, output ready);
endinterface

interface dvpf_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [dvpf_pkg::CFG_INDEX_WIDTH-1:0] index;
	logic [dvpf_pkg::CFG_DATA_WIDTH-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/dvpf_cfg.sv -----
// Configuration register file: gains and integrator limits.
module dvpf_cfg (
	input  logic              clk,
	input  logic              arst_n,
	dvpf_cfg_if.sink          cfg,
	output dvpf_pkg::cfg_t    regs
);

	dvpf_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ff_gain     <= '0;
			regs_q.accel_gain  <= '0;
			regs_q.prop_gain   <= '0;
			regs_q.istep_gain  <= '0;
			regs_q.integ_upper <= dvpf_pkg::INTEG_UPPER_RST;
			regs_q.integ_lower <= dvpf_pkg::INTEG_LOWER_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dvpf_pkg::REG_FF_GAIN:     regs_q.ff_gain    <= cfg.data;
				dvpf_pkg::REG_ACCEL_GAIN:  regs_q.accel_gain <= cfg.data;
				dvpf_pkg::REG_PROP_GAIN:   regs_q.prop_gain  <= cfg.data;
				dvpf_pkg::REG_ISTEP_GAIN:  regs_q.istep_gain <= cfg.data;
				dvpf_pkg::REG_INTEG_UPPER:
					regs_q.integ_upper <= cfg.data[dvpf_pkg::LIMIT_WIDTH-1:0];
				dvpf_pkg::REG_INTEG_LOWER:
					regs_q.integ_lower <= cfg.data[dvpf_pkg::LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/dvpf_chan.sv -----
// One motor channel: input register, term products, integrator and drive register.
module dvpf_chan #(
	parameter int SPEED_WIDTH    = dvpf_pkg::SPEED_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = dvpf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dvpf_pkg::pipe_ctl_t                     ctl,
	input  dvpf_pkg::cfg_t                          regs,
	input  logic signed [SPEED_WIDTH-1:0]           target,
	input  logic signed [SPEED_WIDTH-1:0]           speed,
	output logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] drive
);

	localparam int W      = SPEED_WIDTH;
	localparam int F      = GAIN_FRAC_BITS;
	localparam int GW     = dvpf_pkg::GAIN_WIDTH;
	localparam int LW     = dvpf_pkg::LIMIT_WIDTH;
	localparam int DW     = dvpf_pkg::DRIVE_WIDTH;
	localparam int SH     = dvpf_pkg::STEP_FRAC_BITS - F;
	localparam int ERR_W  = W + 1;
	localparam int ESUM_W = W + 2;
	localparam int FF_W   = GW + W;
	localparam int AC_W   = GW + ERR_W;
	localparam int ST_W   = GW + 1 + ESUM_W;
	localparam int INT_W  = LW + F + 1;
	localparam int SUMI_W = ((ST_W > INT_W) ? ST_W : INT_W) + 1;
	localparam int TOT_W  = ((AC_W > INT_W) ? AC_W : INT_W) + 2;
	localparam logic signed [ST_W-1:0]  STEP_HALF  = ST_W'((1 << SH) >> 1);
	localparam logic signed [TOT_W-1:0] DRIVE_HALF = TOT_W'(1 << (F - 1));

	logic signed [W-1:0]      tgt_s1, spd_s1, last_tgt_q;
	logic signed [ERR_W-1:0]  err, dtgt, last_err_q;
	logic signed [ESUM_W-1:0] esum;
	logic signed [FF_W-1:0]   ff_x, ff_y, ff_s2;
	logic signed [AC_W-1:0]   ac_x, ac_y, ac_s2, p_x, p_y, p_s2;
	logic signed [ST_W-1:0]   st_x, st_y, st_s2, step_r;
	logic signed [SUMI_W-1:0] isum, lim_lo, lim_hi;
	logic signed [INT_W-1:0]  integ_q, integ_nx;
	logic signed [TOT_W-1:0]  total, rnd;
	logic signed [DW-1:0]     drive_nx, drive_q;

	// stage 1: error, target change and the four products
	assign err  = {tgt_s1[W-1], tgt_s1} - {spd_s1[W-1], spd_s1};
	assign dtgt = {tgt_s1[W-1], tgt_s1} - {last_tgt_q[W-1], last_tgt_q};
	assign esum = {err[ERR_W-1], err} + {last_err_q[ERR_W-1], last_err_q};

	assign ff_x = FF_W'($signed(regs.ff_gain));
	assign ff_y = FF_W'(tgt_s1);
	assign ac_x = AC_W'($signed(regs.accel_gain));
	assign ac_y = AC_W'(dtgt);
	assign p_x  = AC_W'($signed(regs.prop_gain));
	assign p_y  = AC_W'(err);
	assign st_x = ST_W'($signed({1'b0, regs.istep_gain}));
	assign st_y = ST_W'(esum);

	// stage 2: integrator update with clamp, then round and saturate
	assign step_r = (st_s2 + STEP_HALF) >>> SH;
	assign isum   = SUMI_W'(integ_q) + SUMI_W'(step_r);
	assign lim_lo = SUMI_W'($signed(regs.integ_lower)) <<< F;
	assign lim_hi = SUMI_W'($signed(regs.integ_upper)) <<< F;

	always_comb begin
		// with crossed limits, a sum below the lower limit takes it and any other sum takes the upper
		if (isum < lim_lo) begin
			integ_nx = INT_W'(lim_lo);
		end else if (isum > lim_hi) begin
			integ_nx = INT_W'(lim_hi);
		end else begin
			integ_nx = INT_W'(isum);
		end
	end

	assign total = TOT_W'(ff_s2) + TOT_W'(ac_s2) + TOT_W'(p_s2) + TOT_W'(integ_nx);
	assign rnd   = (total + DRIVE_HALF) >>> F;

	always_comb begin
		if (rnd > TOT_W'(dvpf_pkg::PWM_MAX)) begin
			drive_nx = dvpf_pkg::PWM_MAX;
		end else if (rnd < TOT_W'(dvpf_pkg::PWM_MIN)) begin
			drive_nx = dvpf_pkg::PWM_MIN;
		end else begin
			drive_nx = rnd[DW-1:0];
		end
	end

	assign drive = drive_q;

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			tgt_s1 <= target;
			spd_s1 <= speed;
		end
		if (ctl.adv_s1) begin
			ff_s2 <= ff_x * ff_y;
			ac_s2 <= ac_x * ac_y;
			p_s2  <= p_x * p_y;
			st_s2 <= st_x * st_y;
		end
		if (ctl.adv_s2) begin
			drive_q <= drive_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tgt_q <= '0;
			last_err_q <= '0;
			integ_q    <= '0;
		end else begin
			if (ctl.adv_s1) begin
				last_tgt_q <= tgt_s1;
				last_err_q <= err;
			end
			if (ctl.adv_s2) begin
				integ_q <= integ_nx;
			end
		end
	end

endmodule

// ----- sv/dual_velocity_pi_feedforward.sv -----
// Pipeline: input register, product register and output register, each holding
// one transaction, carry an accepted sample to its drive command on the output.
// Throughput: one sample per cycle while command.ready stays high.
// Reset: arst_n clears the pipeline, integrators, stored targets and errors,
// zeroes the gains and sets the integrator limits to +50 and -50.
module dual_velocity_pi_feedforward #(
	parameter int SPEED_WIDTH    = dvpf_pkg::SPEED_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = dvpf_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dvpf_in_if.sink     sample,
	dvpf_out_if.source  command,
	dvpf_cfg_if.sink    cfg
);

	dvpf_pkg::cfg_t      regs;
	dvpf_pkg::pipe_ctl_t ctl;
	logic                valid_s1, valid_s2, valid_q;

	// advance a stage when the next one is empty or moving on
	assign ctl.adv_s2  = valid_s2 & (!valid_q | command.ready);
	assign ctl.adv_s1  = valid_s1 & (!valid_s2 | ctl.adv_s2);
	assign sample.ready = !valid_s1 | ctl.adv_s1;
	assign ctl.load_s1 = sample.valid & sample.ready;
	assign command.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_s1 <= ctl.load_s1 | (valid_s1 & !ctl.adv_s1);
			valid_s2 <= ctl.adv_s1 | (valid_s2 & !ctl.adv_s2);
			valid_q  <= ctl.adv_s2 | (valid_q & !command.ready);
		end
	end

	dvpf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dvpf_chan #(
		.SPEED_WIDTH    (SPEED_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_chan_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.regs   (regs),
		.target (sample.target_a),
		.speed  (sample.speed_a),
		.drive  (command.drive_a)
	);

	dvpf_chan #(
		.SPEED_WIDTH    (SPEED_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_chan_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.regs   (regs),
		.target (sample.target_b),
		.speed  (sample.speed_b),
		.drive  (command.drive_b)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (valid_s1 && valid_s2 && valid_q && !command.ready))
		else $error("input stalled while the pipeline has room");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_s1 |=> valid_s1)
		else $error("accepted transaction lost from the input register");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv_s1 |=> valid_s2)
		else $error("transaction lost between stage one and stage two");

	a_drive_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		command.valid |-> (command.drive_a >= dvpf_pkg::PWM_MIN &&
			command.drive_a <= dvpf_pkg::PWM_MAX &&
			command.drive_b >= dvpf_pkg::PWM_MIN &&
			command.drive_b <= dvpf_pkg::PWM_MAX))
		else $error("drive command outside the PWM range");

endmodule

// ----- tb/dual_velocity_pi_feedforward_test.sv -----
// Self-checking testbench of the dual velocity regulator: predicted drives against the outputs.
module dual_velocity_pi_feedforward_test;

	localparam int FRAC        = dvpf_pkg::GAIN_FRAC_BITS_DEF;
	localparam int ISTEP_SHIFT = dvpf_pkg::STEP_FRAC_BITS - dvpf_pkg::GAIN_FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;

	// Indexes that map to no register; writes to them must be dropped.
	localparam logic [dvpf_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [dvpf_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] target_a;
		logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] target_b;
		logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] speed_a;
		logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] speed_b;
	} sample_t;

	typedef struct packed {
		logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] a;
		logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] b;
	} drive_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                        in_valid = 1'b0;
	logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] in_target_a = '0;
	logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] in_target_b = '0;
	logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] in_speed_a = '0;
	logic signed [dvpf_pkg::SPEED_WIDTH_DEF-1:0] in_speed_b = '0;
	logic                                        out_ready = 1'b0;
	logic                                        cfg_valid = 1'b0;
	logic [dvpf_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index = '0;
	logic [dvpf_pkg::CFG_DATA_WIDTH-1:0]         cfg_data = '0;

	dvpf_in_if #(.SPEED_WIDTH(dvpf_pkg::SPEED_WIDTH_DEF)) sample_ch ();
	dvpf_out_if command_ch ();
	dvpf_cfg_if cfg_ch ();

	assign sample_ch.valid    = in_valid;
	assign sample_ch.target_a = in_target_a;
	assign sample_ch.target_b = in_target_b;
	assign sample_ch.speed_a  = in_speed_a;
	assign sample_ch.speed_b  = in_speed_b;
	assign command_ch.ready   = out_ready;
	assign cfg_ch.valid       = cfg_valid;
	assign cfg_ch.index       = cfg_index;
	assign cfg_ch.data        = cfg_data;

	dual_velocity_pi_feedforward #(
		.SPEED_WIDTH(dvpf_pkg::SPEED_WIDTH_DEF),
		.GAIN_FRAC_BITS(dvpf_pkg::GAIN_FRAC_BITS_DEF)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.command(command_ch),
		.cfg(cfg_ch)
	);

	// Regulator state mirrored by the predictor; index 0 is motor A, 1 is motor B.
	longint ff_k = 0;
	longint accel_k = 0;
	longint prop_k = 0;
	longint istep_k = 0;
	longint integ_hi = longint'(dvpf_pkg::INTEG_UPPER_RST);
	longint integ_lo = longint'(dvpf_pkg::INTEG_LOWER_RST);
	longint integ_acc [2] = '{0, 0};
	longint prev_err [2] = '{0, 0};
	longint prev_tgt [2] = '{0, 0};

	sample_t     sample_backlog [$];
	drive_pair_t drive_due [$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatches = 0;
	int          cycles = 0;

	// Round to nearest, ties toward +infinity.
	function automatic longint round_half_up(input longint x, input int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] drive_for(input int m,
			input longint tgt, input longint spd);
		longint err, ff, p, step, lo, hi, acc;
		err = tgt - spd;
		ff = ff_k * tgt + accel_k * (tgt - prev_tgt[m]);
		p = prop_k * err;
		step = round_half_up(istep_k * (err + prev_err[m]), ISTEP_SHIFT);
		lo = integ_lo * (longint'(1) <<< FRAC);
		hi = integ_hi * (longint'(1) <<< FRAC);
		acc = integ_acc[m] + step;
		// with crossed limits, a sum below the lower limit takes it and any other sum takes the upper
		if (acc < lo)
			acc = lo;
		else if (acc > hi)
			acc = hi;
		integ_acc[m] = acc;
		prev_tgt[m] = tgt;
		prev_err[m] = err;
		acc = round_half_up(ff + p + acc, FRAC);
		if (acc > longint'(dvpf_pkg::PWM_MAX))
			acc = longint'(dvpf_pkg::PWM_MAX);
		else if (acc < longint'(dvpf_pkg::PWM_MIN))
			acc = longint'(dvpf_pkg::PWM_MIN);
		return acc[dvpf_pkg::DRIVE_WIDTH-1:0];
	endfunction

	function automatic logic [dvpf_pkg::GAIN_WIDTH-1:0] pick_gain();
		if ($urandom_range(3) == 0)
			return dvpf_pkg::GAIN_WIDTH'($urandom);
		return dvpf_pkg::GAIN_WIDTH'($urandom_range(1024) - 512);
	endfunction

	task automatic flag(input string what,
			input logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] want,
			input logic signed [dvpf_pkg::DRIVE_WIDTH-1:0] got);
		mismatches++;
		$display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
	endtask

	task automatic queue_sample(input logic [15:0] t_a, input logic [15:0] t_b,
			input logic [15:0] s_a, input logic [15:0] s_b);
		sample_t item;
		item.target_a = t_a;
		item.target_b = t_b;
		item.speed_a = s_a;
		item.speed_b = s_b;
		sample_backlog.push_back(item);
	endtask

	task automatic write_reg(input logic [dvpf_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [dvpf_pkg::CFG_DATA_WIDTH-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [15:0] ff, input logic [15:0] accel,
			input logic [15:0] prop, input logic [15:0] istep, input int upper, input int lower);
		write_reg(dvpf_pkg::REG_FF_GAIN, ff);
		write_reg(dvpf_pkg::REG_ACCEL_GAIN, accel);
		write_reg(dvpf_pkg::REG_PROP_GAIN, prop);
		write_reg(dvpf_pkg::REG_ISTEP_GAIN, istep);
		write_reg(dvpf_pkg::REG_INTEG_UPPER, 16'(upper));
		write_reg(dvpf_pkg::REG_INTEG_LOWER, 16'(lower));
	endtask

	// Wait until every queued sample is sent and every drive has come back.
	// Look at the falling edge, when the rising-edge updates have settled.
	task automatic drain();
		do
			@(negedge clk);
		while (sample_backlog.size() != 0 || in_valid || drive_due.size() != 0);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sample driver: hold the transaction until it is taken.
	always @(posedge clk) begin
		sample_t next;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || sample_ch.ready) begin
			if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next = sample_backlog.pop_front();
				in_valid <= 1'b1;
				in_target_a <= next.target_a;
				in_target_b <= next.target_b;
				in_speed_a <= next.speed_a;
				in_speed_b <= next.speed_b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check drives, then predict from accepted samples and register writes.
	always @(posedge clk) begin
		drive_pair_t want;
		if (arst_n) begin
			if (out_ready && command_ch.valid) begin
				if (drive_due.size() == 0) begin
					mismatches++;
					$display("%0t unexpected drive: expected none actual %0d %0d", $time,
						command_ch.drive_a, command_ch.drive_b);
				end else begin
					want = drive_due.pop_front();
					if (command_ch.drive_a !== want.a)
						flag("drive_a", want.a, command_ch.drive_a);
					if (command_ch.drive_b !== want.b)
						flag("drive_b", want.b, command_ch.drive_b);
				end
			end
			if (in_valid && sample_ch.ready) begin
				want.a = drive_for(0, longint'(in_target_a), longint'(in_speed_a));
				want.b = drive_for(1, longint'(in_target_b), longint'(in_speed_b));
				drive_due.push_back(want);
			end
			if (cfg_valid && cfg_ch.ready) begin
				case (cfg_index)
					dvpf_pkg::REG_FF_GAIN:     ff_k = longint'($signed(cfg_data));
					dvpf_pkg::REG_ACCEL_GAIN:  accel_k = longint'($signed(cfg_data));
					dvpf_pkg::REG_PROP_GAIN:   prop_k = longint'($signed(cfg_data));
					dvpf_pkg::REG_ISTEP_GAIN:  istep_k = longint'(cfg_data);
					dvpf_pkg::REG_INTEG_UPPER:
						integ_hi = longint'($signed(cfg_data[dvpf_pkg::LIMIT_WIDTH-1:0]));
					dvpf_pkg::REG_INTEG_LOWER:
						integ_lo = longint'($signed(cfg_data[dvpf_pkg::LIMIT_WIDTH-1:0]));
					default: ;
				endcase
			end
		end
	end

	initial begin
		int wa, wb, st, span, hi_lim, lo_lim, swap;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: gains are zero, so drives stay at zero
		queue_sample(16'd1234, -16'sd1234, 16'd0, 16'd77);
		queue_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		drain();

		// half gain on the target: exercises ties of the rounding
		configure(16'h0080, 16'h0000, 16'h0000, 16'h0000, 50, -50);
		queue_sample(16'd1, -16'sd1, 16'd0, 16'd0);
		queue_sample(16'd3, -16'sd3, 16'd0, 16'd0);
		drain();

		configure(16'h0100, 16'h0080, 16'h0200, 16'h8000, 1023, -1023);
		queue_sample(16'd0, 16'd0, 16'd0, 16'd0);
		queue_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		queue_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		queue_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		queue_sample(16'd100, -16'sd100, 16'd90, -16'sd110);
		queue_sample(16'd100, -16'sd100, 16'd90, -16'sd110);
		queue_sample(16'd0, 16'd0, 16'd0, 16'd0);
		queue_sample(16'd5, -16'sd5, 16'd0, 16'd0);
		drain();

		// writes to unused indexes must leave every register alone
		write_reg(REG_SPARE_6, 16'h7FFF);
		write_reg(REG_SPARE_7, 16'h8001);
		queue_sample(16'd200, 16'd300, 16'd150, 16'd350);
		drain();

		// crossed limits: lower above upper
		configure(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, -20, 30);
		queue_sample(16'd1000, -16'sd1000, 16'd0, 16'd0);
		queue_sample(16'd1000, -16'sd1000, 16'd0, 16'd0);
		queue_sample(16'd1000, -16'sd1000, 16'd0, 16'd0);
		queue_sample(16'd0, 16'd0, 16'd0, 16'd0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: configure(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1023, -1023);
				1: configure(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, -1023, 1023);
				default: begin
					hi_lim = $urandom_range(1023);
					lo_lim = -int'($urandom_range(1023));
					if ($urandom_range(4) == 0) begin
						swap = hi_lim;
						hi_lim = lo_lim;
						lo_lim = swap;
					end
					configure(pick_gain(), pick_gain(), pick_gain(), 16'($urandom), hi_lim,
						lo_lim);
				end
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 47; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 47; end
				default: begin send_idle_pct = 19; stall_pct = 19; end
			endcase
			span = (ph < 2) ? 30000 : (250 << (ph % 4));
			st = span / 16 + 1;
			wa = 0;
			wb = 0;
			// mostly smooth target ramps with measured speed close behind, some noise
			for (int n = 0; n < 125; n++) begin
				if ($urandom_range(9) == 0) begin
					queue_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				end else begin
					wa += int'($urandom_range(2 * st)) - st;
					wb += int'($urandom_range(2 * st)) - st;
					if (wa > span) wa = span;
					if (wa < -span) wa = -span;
					if (wb > span) wb = span;
					if (wb < -span) wb = -span;
					queue_sample(16'(wa), 16'(wb), 16'(wa + int'($urandom_range(2 * st)) - st),
						16'(wb + int'($urandom_range(2 * st)) - st));
				end
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/dvpf_pkg.sv
sv/dvpf_if.sv
sv/dvpf_cfg.sv
sv/dvpf_chan.sv
sv/dual_velocity_pi_feedforward.sv
tb/dual_velocity_pi_feedforward_test.sv
